// File: hdl/mbps_pkg.sv
// Shared types and codes for the masked byte pattern search core.
// Used by the cell, the scan tracker and the top level; depends on nothing.
package mbps_pkg;

  // Item operation codes; the fourth code only yields a result and clears match_now.
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_SCAN    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [1:0] CFG_START_ADDRESS  = 2'd1;
  localparam logic [1:0] CFG_SEARCH_LIMIT   = 2'd2;

  localparam int unsigned LENGTH_W = 7;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned LIMIT_W  = 32;
  localparam int unsigned SEEN_W   = 33;
  localparam int unsigned CFG_W    = 64;

  // Window control shared by every cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // One accepted item as seen by the tracker.
  typedef struct packed {
    logic accept;
    logic scan;
    logic restart;
    logic hit;
  } step_t;

  // Scan status shown on the result channel.
  typedef struct packed {
    logic              found;
    logic              match_now;
    logic [ADDR_W-1:0] match_address;
    logic              exhausted;
  } status_t;

endpackage

// File: hdl/mbps_if.sv
// Valid/ready channel interfaces for items and results of the search core.
// Stand-alone; no package needed.
interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [5:0] entry_index;
  logic [7:0] data_byte;
  logic       care;

  modport source (output valid, opcode, entry_index, data_byte, care, input ready);
  modport sink   (input valid, opcode, entry_index, data_byte, care, output ready);
endinterface

interface mbps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic        match_now;
  logic [63:0] match_address;
  logic        exhausted;

  modport source (output valid, found, match_now, match_address, exhausted, input ready);
  modport sink   (input valid, found, match_now, match_address, exhausted, output ready);
endinterface

// File: hdl/mbps_cell.sv
// One cell of the search row: a window byte that moves on to the next cell,
// one pattern entry with its care bit, and the compare for that entry. Uses mbps_pkg.
module mbps_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbps_pkg::cell_ctl_t ctl_i,
  input  logic [7:0]          win_i,
  output logic [7:0]          win_o,
  input  logic                load_i,
  input  logic [7:0]          load_byte_i,
  input  logic                load_care_i,
  input  logic [7:0]          cmp_byte_i,
  input  logic                active_i,
  output logic                hit_o
);
  import mbps_pkg::*;

  logic [7:0] win_q;
  logic [7:0] pat_q;
  logic       care_q;

  // Advance the window byte, or drop it on restart.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 8'd0;
    end else if (ctl_i.clear) begin
      win_q <= 8'd0;
    end else if (ctl_i.shift) begin
      win_q <= win_i;
    end
  end

  // Hold the pattern entry until it is loaded again.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pat_q  <= load_byte_i;
      care_q <= load_care_i;
    end
  end

  assign win_o = win_q;
  // Positions past the pattern length and wildcards always pass.
  assign hit_o = !active_i || !care_q || (cmp_byte_i == pat_q);

endmodule

// File: hdl/mbps_tracker.sv
// Scan bookkeeping: byte count, first-match latch and offset, and status.
// Uses mbps_pkg; driven by the top level with the combined window hit.
module mbps_tracker #(
  parameter int unsigned LenW = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mbps_pkg::step_t                step_i,
  input  logic [LenW-1:0]                len_i,
  input  logic [mbps_pkg::LIMIT_W-1:0]   limit_i,
  input  logic [mbps_pkg::ADDR_W-1:0]    start_i,
  output mbps_pkg::status_t              status_o
);
  import mbps_pkg::*;

  localparam logic [SEEN_W-1:0] SeenMax = {SEEN_W{1'b1}};

  logic [SEEN_W-1:0]  seen_q, seen_d;
  logic               latched_q, latched_d;
  logic [LIMIT_W-1:0] offset_q, offset_d;
  logic               now_q, now_d;

  logic [SEEN_W-1:0]  seen_inc;
  logic [SEEN_W-1:0]  len_ext;
  logic [SEEN_W-1:0]  start_pos;
  logic               take;
  logic [SEEN_W:0]    exh_lhs;
  logic [SEEN_W:0]    exh_rhs;

  // Count with saturation; test the start position of the window.
  assign seen_inc  = (seen_q == SeenMax) ? seen_q : seen_q + SEEN_W'(1);
  assign len_ext   = SEEN_W'(len_i);
  assign start_pos = seen_inc - len_ext;
  assign take      = step_i.scan && !latched_q && (seen_inc >= len_ext) &&
                     (start_pos < {1'b0, limit_i}) && step_i.hit;

  always_comb begin
    seen_d    = seen_q;
    latched_d = latched_q;
    offset_d  = offset_q;
    now_d     = now_q;
    if (step_i.accept) begin
      now_d = 1'b0;
    end
    if (step_i.scan) begin
      seen_d = seen_inc;
      if (take) begin
        latched_d = 1'b1;
        offset_d  = start_pos[LIMIT_W-1:0];
        now_d     = 1'b1;
      end
    end
    if (step_i.restart) begin
      seen_d    = '0;
      latched_d = 1'b0;
      offset_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      latched_q <= 1'b0;
      offset_q  <= '0;
      now_q     <= 1'b0;
    end else begin
      seen_q    <= seen_d;
      latched_q <= latched_d;
      offset_q  <= offset_d;
      now_q     <= now_d;
    end
  end

  // Status after the last item; the user holds configuration while shown; not enforced.
  assign exh_lhs = (SEEN_W+1)'(seen_q) + (SEEN_W+1)'(1);
  assign exh_rhs = (SEEN_W+1)'(limit_i) + (SEEN_W+1)'(len_i);

  assign status_o.found         = latched_q;
  assign status_o.match_now     = now_q;
  assign status_o.match_address = latched_q ? (start_i + ADDR_W'(offset_q)) : '0;
  assign status_o.exhausted     = !latched_q &&
                                  ((limit_i == '0) || (exh_lhs >= exh_rhs));

endmodule

// File: hdl/masked_byte_pattern_search_core.sv
// Masked byte pattern search core: top level with the cell row, the window
// alignment shifter, the configuration registers and the result register.
// Uses mbps_pkg, mbps_if, mbps_cell and mbps_tracker.
//
// Every item (load, scan byte, restart) yields one result transfer; a new item
// is taken in the same cycle that the previous result leaves, so with a ready
// sink the core sustains one item per cycle. A scan byte shifts into a row of
// MAX_PATTERN cells; all cells compare their pattern entry against the aligned
// window in that same cycle, and the single result register is what paces the
// input: while a result waits, input stalls. Patterns are written one entry per
// load item; the user must write configuration through the plain write port
// only while the core is idle, which the core itself does not enforce.
module masked_byte_pattern_search_core #(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [mbps_pkg::CFG_W-1:0]  cfg_data_i,
  mbps_in_if.sink                     in_i,
  mbps_out_if.source                  out_o
);
  import mbps_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned CmpW = (LenW > LENGTH_W) ? LenW : LENGTH_W;
  localparam int unsigned ShW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned IdxW = (ShW > 6) ? ShW : 6;

  // Configuration registers.
  logic [LENGTH_W-1:0] pattern_length_q;
  logic [ADDR_W-1:0]   start_address_q;
  logic [LIMIT_W-1:0]  search_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q <= LENGTH_W'(1);
      start_address_q  <= '0;
      search_limit_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data_i[LENGTH_W-1:0];
        CFG_START_ADDRESS:  start_address_q  <= cfg_data_i[ADDR_W-1:0];
        CFG_SEARCH_LIMIT:   search_limit_q   <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the pattern length to 1..MAX_PATTERN.
  logic [CmpW-1:0] plen_ext;
  logic [LenW-1:0] len_used;

  assign plen_ext = CmpW'(pattern_length_q);

  always_comb begin
    if (plen_ext == '0) begin
      len_used = LenW'(1);
    end else if (plen_ext > CmpW'(MAX_PATTERN)) begin
      len_used = LenW'(MAX_PATTERN);
    end else begin
      len_used = plen_ext[LenW-1:0];
    end
  end

  // Handshake: take an item when the result register is free or drains now.
  logic out_valid_q;
  logic in_ready;
  logic accept;

  assign in_ready   = !out_valid_q || out_o.ready;
  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Decode the item.
  logic is_load;
  logic is_scan;
  logic is_restart;

  always_comb begin
    is_load    = 1'b0;
    is_scan    = 1'b0;
    is_restart = 1'b0;
    unique case (in_i.opcode)
      OP_LOAD:    is_load    = accept;
      OP_SCAN:    is_scan    = accept;
      OP_RESTART: is_restart = accept;
      default: ;
    endcase
  end

  cell_ctl_t cell_ctl;
  assign cell_ctl.shift = is_scan;
  assign cell_ctl.clear = is_restart;

  // Cell row: nw[k] is the window byte cell k holds after this scan byte.
  logic [7:0]             win [MAX_PATTERN];
  logic [7:0]             nw  [MAX_PATTERN];
  logic [7:0]             aligned [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit;
  logic [MAX_PATTERN-1:0] active;

  assign nw[0] = in_i.data_byte;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    if (k > 0) begin : g_link
      assign nw[k] = win[k-1];
    end

    logic load_sel;
    assign load_sel  = is_load && (IdxW'(in_i.entry_index) == IdxW'(k));
    assign active[k] = len_used > LenW'(k);

    mbps_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (cell_ctl),
      .win_i       (nw[k]),
      .win_o       (win[k]),
      .load_i      (load_sel),
      .load_byte_i (in_i.data_byte),
      .load_care_i (in_i.care),
      .cmp_byte_i  (aligned[k]),
      .active_i    (active[k]),
      .hit_o       (hit[k])
    );
  end

  // Align the window: pattern entry k meets window byte len-1-k.
  // Reverse the row, then shift down by MAX_PATTERN - len.
  logic [LenW-1:0] sh_full;
  logic [ShW-1:0]  sh;
  logic [7:0]      stg [ShW+1][MAX_PATTERN];

  assign sh_full = LenW'(MAX_PATTERN) - len_used;
  assign sh      = sh_full[ShW-1:0];

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_rev
    assign stg[0][j]  = nw[MAX_PATTERN-1-j];
    assign aligned[j] = stg[ShW][j];
  end

  for (genvar l = 0; l < ShW; l++) begin : g_lvl
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pos
      if (j + (1 << l) < MAX_PATTERN) begin : g_in
        assign stg[l+1][j] = sh[l] ? stg[l][j + (1 << l)] : stg[l][j];
      end else begin : g_out
        assign stg[l+1][j] = sh[l] ? 8'd0 : stg[l][j];
      end
    end
  end

  // Scan bookkeeping and status.
  step_t   step;
  status_t status;

  assign step.accept  = accept;
  assign step.scan    = is_scan;
  assign step.restart = is_restart;
  assign step.hit     = &hit;

  mbps_tracker #(
    .LenW (LenW)
  ) u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .len_i    (len_used),
    .limit_i  (search_limit_q),
    .start_i  (start_address_q),
    .status_o (status)
  );

  // Result channel.
  assign out_o.valid         = out_valid_q;
  assign out_o.found         = status.found;
  assign out_o.match_now     = status.match_now;
  assign out_o.match_address = status.match_address;
  assign out_o.exhausted     = status.exhausted;

endmodule
